// File: hw/rtl/i2cbm_pkg.sv
// Shared types and constants for the I2C bit-level master.
// Used by the channel interface users and the top level; no dependencies.
package i2cbm_pkg;

  localparam int BYTE_BITS = 8;
  localparam int BIT_CNT_W = $clog2(BYTE_BITS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd255;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_level;
  } req_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_out;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } rsp_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_item_t;

endpackage

// File: hw/rtl/i2cbm_chan_if.sv
// Valid/ready channel carrying one payload beat of type T.
// Payload types come from i2cbm_pkg at the point of instantiation.
interface i2cbm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i2c_bit_level_master_unit.sv
// I2C bit-level master: one tick beat in, one pin/status beat out.
// A result beat is buffered when its tick beat is taken and reaches rsp in order.
// One tick beat per cycle while the buffer has room; single-pass engine update.
// A two-beat output buffer lets ticks keep flowing while one result waits.
// Reset (rst, synchronous, active high): idle, SCL/SDA high and driven, config to
// half period 2 and ack timeout 255, read data and no_ack cleared, buffer empty.
module i2c_bit_level_master_unit (
  input  logic         clk,
  input  logic         rst,
  i2cbm_chan_if.sink   req,
  i2cbm_chan_if.source rsp,
  i2cbm_chan_if.sink   cfg
);
  import i2cbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_WL, PH_WH,
    PH_A1, PH_A2, PH_AP, PH_RL, PH_RH, PH_KL, PH_KH
  } phase_t;

  // Configuration registers
  logic [15:0] half_period_ticks;
  logic [7:0]  ack_timeout_ticks;

  // Engine state
  phase_t               phase, phase_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [BYTE_BITS-1:0] shift_byte, shift_byte_next;
  logic [15:0]          tick_count, tick_count_next;
  logic [7:0]           ack_wait_count, ack_wait_count_next;
  logic                 ack_choice, ack_choice_next;
  logic                 scl_reg, scl_reg_next;
  logic                 sda_reg, sda_reg_next;
  logic                 sda_enable_reg, sda_enable_reg_next;
  logic                 ack_fail_flag, ack_fail_flag_next;
  logic [7:0]           last_read, last_read_next;
  logic                 done;

  // Output buffer, two beats deep
  rsp_item_t  slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  logic      req_fire, rsp_fire;
  req_item_t it;
  rsp_item_t push_data;

  logic [15:0]          hp, tick_inc;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [BYTE_BITS-1:0] shift_wr, shift_rd;
  logic [7:0]           awc_dec;

  assign cfg.ready = 1'b1;
  assign req.ready = (count != 2'd2);
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign rsp.valid = (count != 2'd0);
  assign rsp.data  = slot[rd_ptr];
  assign it        = req.data;

  // Zero half period behaves as one tick
  assign hp       = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign tick_inc = tick_count + 16'd1;
  assign bit_inc  = bit_count + BIT_CNT_W'(1);
  assign shift_wr = {shift_byte[BYTE_BITS-2:0], 1'b0};
  assign shift_rd = {shift_byte[BYTE_BITS-2:0], it.sda_level};
  assign awc_dec  = (ack_wait_count != 8'd0) ? ack_wait_count - 8'd1 : 8'd0;

  // Next engine state for the tick being taken
  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    tick_count_next     = tick_count;
    ack_wait_count_next = ack_wait_count;
    ack_choice_next     = ack_choice;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    sda_enable_reg_next = sda_enable_reg;
    ack_fail_flag_next  = ack_fail_flag;
    last_read_next      = last_read;
    done                = 1'b0;

    if (phase == PH_IDLE) begin
      if (it.cmd_valid) begin
        tick_count_next = 16'd0;
        case (it.opcode)
          OP_START: begin
            sda_enable_reg_next = 1'b1;
            sda_reg_next        = 1'b1;
            scl_reg_next        = 1'b1;
            phase_next          = PH_S1;
          end
          OP_STOP: begin
            sda_enable_reg_next = 1'b1;
            scl_reg_next        = 1'b0;
            sda_reg_next        = 1'b0;
            phase_next          = PH_P1;
          end
          OP_WRITE: begin
            ack_fail_flag_next  = 1'b0;
            shift_byte_next     = it.write_byte;
            bit_count_next      = '0;
            sda_enable_reg_next = 1'b1;
            scl_reg_next        = 1'b0;
            sda_reg_next        = it.write_byte[BYTE_BITS-1];
            phase_next          = PH_WL;
          end
          default: begin
            ack_choice_next     = it.send_ack;
            shift_byte_next     = '0;
            bit_count_next      = '0;
            sda_enable_reg_next = 1'b0;
            scl_reg_next        = 1'b0;
            phase_next          = PH_RL;
          end
        endcase
      end
    end else if (phase == PH_AP) begin
      // Poll for acknowledge once per tick
      if (ack_wait_count != 8'd0 && !it.sda_level) begin
        scl_reg_next       = 1'b0;
        ack_fail_flag_next = 1'b0;
        phase_next         = PH_IDLE;
        done               = 1'b1;
      end else begin
        ack_wait_count_next = awc_dec;
        if (awc_dec == 8'd0) begin
          // timeout: flag and run the stop sequence
          ack_fail_flag_next  = 1'b1;
          sda_enable_reg_next = 1'b1;
          scl_reg_next        = 1'b0;
          sda_reg_next        = 1'b0;
          tick_count_next     = 16'd0;
          phase_next          = PH_P1;
        end
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= hp) begin
        tick_count_next = 16'd0;
        case (phase)
          PH_S1: begin
            sda_reg_next = 1'b0;
            phase_next   = PH_S2;
          end
          PH_S2: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_P1: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_P2;
          end
          PH_P2: begin
            sda_reg_next = 1'b1;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_WL: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_WH;
          end
          PH_WH: begin
            scl_reg_next    = 1'b0;
            bit_count_next  = bit_inc;
            shift_byte_next = shift_wr;
            if (bit_inc < BIT_CNT_W'(BYTE_BITS)) begin
              sda_reg_next = shift_wr[BYTE_BITS-1];
              phase_next   = PH_WL;
            end else begin
              // release SDA before the ack clock
              sda_reg_next        = 1'b1;
              sda_enable_reg_next = 1'b0;
              phase_next          = PH_A1;
            end
          end
          PH_A1: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_A2;
          end
          PH_A2: begin
            ack_wait_count_next = ack_timeout_ticks;
            phase_next          = PH_AP;
          end
          PH_RL: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_RH;
          end
          PH_RH: begin
            shift_byte_next = shift_rd;
            scl_reg_next    = 1'b0;
            bit_count_next  = bit_inc;
            if (bit_inc < BIT_CNT_W'(BYTE_BITS)) begin
              phase_next = PH_RL;
            end else begin
              sda_enable_reg_next = 1'b1;
              sda_reg_next        = !ack_choice;
              phase_next          = PH_KL;
            end
          end
          PH_KL: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_KH;
          end
          PH_KH: begin
            scl_reg_next   = 1'b0;
            last_read_next = shift_byte;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    push_data.scl_level        = scl_reg_next;
    push_data.sda_out          = sda_reg_next;
    push_data.sda_drive_enable = sda_enable_reg_next;
    push_data.busy_res         = (phase_next != PH_IDLE);
    push_data.done_res         = done;
    push_data.read_data        = last_read_next;
    push_data.no_ack           = ack_fail_flag_next;
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.data.reg_index == REG_HALF_PERIOD) begin
        half_period_ticks <= cfg.data.wr_data;
      end
      if (cfg.data.reg_index == REG_ACK_TIMEOUT) begin
        ack_timeout_ticks <= cfg.data.wr_data[7:0];
      end
    end
  end

  // Engine state, advanced once per accepted tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shift_byte     <= '0;
      tick_count     <= 16'd0;
      ack_wait_count <= 8'd0;
      ack_choice     <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      sda_enable_reg <= 1'b1;
      ack_fail_flag  <= 1'b0;
      last_read      <= 8'd0;
    end else if (req_fire) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      tick_count     <= tick_count_next;
      ack_wait_count <= ack_wait_count_next;
      ack_choice     <= ack_choice_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      sda_enable_reg <= sda_enable_reg_next;
      ack_fail_flag  <= ack_fail_flag_next;
      last_read      <= last_read_next;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (req_fire) begin
        wr_ptr <= !wr_ptr;
      end
      if (rsp_fire) begin
        rd_ptr <= !rd_ptr;
      end
      case ({req_fire, rsp_fire})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Buffer payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_fire) begin
      slot[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire && push_data.done_res |-> !push_data.busy_res)
    else $error("done beat still reports busy");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == 16'd0)
    else $error("tick counter not cleared while idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BIT_CNT_W'(BYTE_BITS))
    else $error("bit counter past byte length");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> rsp.valid)
    else $error("accepted tick produced no result beat");
`endif

endmodule
